/* src/tpe_pkg.sv */
// Shared widths, result codes and vertex-table request types for the
// tree to Pruefer encoder. No dependencies.
package tpe_pkg;

    localparam int VTX_W  = 6;
    localparam int DEG_W  = 7;
    localparam int CFG_W  = 7;
    localparam int EDGE_W = 2 * VTX_W;

    localparam logic [DEG_W-1:0] DEG_MAX  = 7'd127;
    localparam logic [CFG_W-1:0] VC_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_ENTRY  = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_NOTREE = 2'd2,
        ST_SMALL  = 2'd3
    } tpe_status_t;

    // One access slot of the vertex table: optional clear, one write, one read.
    typedef struct packed {
        logic             clr;
        logic             we;
        logic [VTX_W-1:0] waddr;
        logic [DEG_W-1:0] wdeg;
        logic [VTX_W-1:0] wpar;
        logic [VTX_W-1:0] raddr;
    } tpe_vreq_t;

    typedef struct packed {
        logic [VTX_W-1:0] addr;
        logic [DEG_W-1:0] deg;
        logic [VTX_W-1:0] par;
    } tpe_vrsp_t;

endpackage

/* src/tpe_edge_mem.sv */
// Edge table of the tree to Pruefer encoder: one write port, one registered
// read port. Depends on tpe_pkg for the edge width.
module tpe_edge_mem #(
    parameter int DEPTH = 63,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [tpe_pkg::EDGE_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [tpe_pkg::EDGE_W-1:0] rdata
);
    import tpe_pkg::*;

    logic [EDGE_W-1:0] mem [DEPTH];
    logic [EDGE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/tpe_vertex_mem.sv */
// Vertex table: degree and union-find parent per vertex, with one valid flag
// per entry so a whole-table clear only resets the flags. Depends on tpe_pkg.
module tpe_vertex_mem #(
    parameter int MAX_VERTICES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tpe_pkg::tpe_vreq_t req,
    output tpe_pkg::tpe_vrsp_t rsp
);
    import tpe_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    typedef struct packed {
        logic [DEG_W-1:0] deg;
        logic [VTX_W-1:0] par;
    } vent_t;

    vent_t                   mem [MAX_VERTICES];
    vent_t                   rd_data_reg;
    logic [MAX_VERTICES-1:0] vld_reg;
    logic [MAX_VERTICES-1:0] vld_next;
    logic                    rd_vld_reg;
    logic                    rd_vld_next;
    logic [VTX_W-1:0]        rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[VW-1:0]] <= '{deg: req.wdeg, par: req.wpar};
        end
        rd_data_reg <= mem[req.raddr[VW-1:0]];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (req.clr)
        begin
            vld_next = '0;
        end
        else if (req.we)
        begin
            vld_next[req.waddr[VW-1:0]] = 1'b1;
        end
        // a clear in the same cycle hides the old contents from this read
        rd_vld_next = !req.clr && vld_reg[req.raddr[VW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            vld_reg     <= vld_next;
            rd_vld_reg  <= rd_vld_next;
            rd_addr_reg <= req.raddr;
        end
    end

    // an entry not written since the last clear reads as degree zero, own root
    assign rsp.addr = rd_addr_reg;
    assign rsp.deg  = rd_vld_reg ? rd_data_reg.deg : '0;
    assign rsp.par  = rd_vld_reg ? rd_data_reg.par : rd_addr_reg;

endmodule

/* src/tree_to_prufer_encoder_top.sv */
// Edge item: the union-find roots of both endpoints are found, one vertex-table read per hop;
// both degrees are bumped, then distinct roots are linked. Bad endpoints skip the table.
// Final edge: S_FIN checks the edge count and ranges; a tree is then walked leaf by leaf,
// each leaf scanning the stored edges for its neighbour, which is emitted as an entry.
// Results are one-cycle strobes on done; the receiver cannot stall.
// Reset (async, rst_n low): sequencer, edge count, vertex count, valid flags reset; no sweep.
module tree_to_prufer_encoder_top #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      vertex_count_we,
    input  logic [tpe_pkg::CFG_W-1:0] vertex_count,
    input  logic                      start,
    output logic                      busy,
    input  logic [tpe_pkg::VTX_W-1:0] end_a,
    input  logic [tpe_pkg::VTX_W-1:0] end_b,
    input  logic                      last_edge,
    output logic                      done,
    output logic [1:0]                status,
    output logic [tpe_pkg::VTX_W-1:0] vertex,
    output logic                      last
);
    import tpe_pkg::*;

    localparam int EW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES - 1) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CFG_W-1:0] MAX_V = CFG_W'(MAX_VERTICES);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_FIND_A  = 13'b0000000000010,
        S_FIND_B  = 13'b0000000000100,
        S_BUMP_A  = 13'b0000000001000,
        S_BUMP_B  = 13'b0000000010000,
        S_LINK_RD = 13'b0000000100000,
        S_LINK    = 13'b0000001000000,
        S_FIN     = 13'b0000010000000,
        S_WALK_U  = 13'b0000100000000,
        S_SCAN_V  = 13'b0001000000000,
        S_SCAN_D  = 13'b0010000000000,
        S_DEC     = 13'b0100000000000,
        S_NEXT_U  = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [VTX_W-1:0]  a_reg, a_next;
    logic [VTX_W-1:0]  b_reg, b_next;
    logic              fin_reg, fin_next;
    logic [CW-1:0]     ecnt_reg, ecnt_next;
    logic              err_reg, err_next;
    logic [VTX_W-1:0]  maxe_reg, maxe_next;
    logic [VTX_W-1:0]  ra_reg, ra_next;
    logic [VTX_W-1:0]  rb_reg, rb_next;
    logic [VTX_W-1:0]  u_reg, u_next;
    logic [VTX_W-1:0]  leaf_reg, leaf_next;
    logic [EW-1:0]     e_reg, e_next;
    logic [VTX_W-1:0]  ocnt_reg, ocnt_next;
    logic [CFG_W-1:0]  vc_reg, vc_next;
    logic              done_reg, done_next;
    tpe_status_t       status_reg, status_next;
    logic [VTX_W-1:0]  vertex_reg, vertex_next;
    logic              last_reg, last_next;

    tpe_vreq_t         vreq;
    tpe_vrsp_t         vrsp;
    logic              e_we;
    logic [EW-1:0]     e_waddr;
    logic [EDGE_W-1:0] e_wdata;
    logic [EW-1:0]     e_raddr;
    logic [EDGE_W-1:0] e_rdata;

    logic [CFG_W-1:0]  n;
    logic              first_edge, store_ok, bad_end, root_hit;
    logic [VTX_W-1:0]  max_base, max_ab;
    logic [VTX_W-1:0]  ex, ey, other;
    logic              hit_x, hit_y, last_e, u_end;
    logic [DEG_W-1:0]  dec_deg;
    logic              step_cont, step_last, do_step;

    tpe_vertex_mem #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_vtx (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (vreq),
        .rsp  (vrsp)
    );

    tpe_edge_mem #(
        .DEPTH(MAX_VERTICES - 1)
    ) u_edge (
        .clk  (clk),
        .we   (e_we),
        .waddr(e_waddr),
        .wdata(e_wdata),
        .raddr(e_raddr),
        .rdata(e_rdata)
    );

    always_comb
    begin
        n          = vc_reg;
        vc_next    = vertex_count_we ? vertex_count : vc_reg;
        first_edge = (ecnt_reg == '0);
        store_ok   = (ecnt_reg < CW'(MAX_VERTICES - 1));
        bad_end    = (end_a == end_b) || ({1'b0, end_a} >= MAX_V)
                     || ({1'b0, end_b} >= MAX_V);
        max_base   = first_edge ? '0 : maxe_reg;
        max_ab     = (end_a > end_b) ? end_a : end_b;
        root_hit   = (vrsp.par == vrsp.addr);

        ex    = e_rdata[EDGE_W-1:VTX_W];
        ey    = e_rdata[VTX_W-1:0];
        hit_x = (ex == leaf_reg);
        hit_y = (ey == leaf_reg);
        other = hit_x ? ey : ex;
        last_e = (CFG_W'(e_reg) == n - CFG_W'(2));
        u_end  = ({1'b0, u_reg} == n - CFG_W'(1));

        dec_deg   = (vrsp.deg != '0) ? vrsp.deg - DEG_W'(1) : '0;
        step_cont = (dec_deg == DEG_W'(1)) && (vrsp.addr <= u_reg);
        step_last = (CFG_W'(ocnt_reg) + CFG_W'(3) == n);

        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        fin_next    = fin_reg;
        ecnt_next   = ecnt_reg;
        err_next    = err_reg;
        maxe_next   = maxe_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        u_next      = u_reg;
        leaf_next   = leaf_reg;
        e_next      = e_reg;
        ocnt_next   = ocnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        vertex_next = vertex_reg;
        last_next   = last_reg;
        vreq        = '0;
        e_we        = 1'b0;
        e_waddr     = ecnt_reg[EW-1:0];
        e_wdata     = {end_a, end_b};
        e_raddr     = '0;
        do_step     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next    = end_a;
                    b_next    = end_b;
                    fin_next  = last_edge;
                    vreq.clr  = first_edge;
                    e_we      = store_ok;
                    maxe_next = (store_ok && max_ab > max_base) ? max_ab : max_base;
                    if (ecnt_reg < CW'(MAX_VERTICES))
                    begin
                        ecnt_next = ecnt_reg + CW'(1);
                    end
                    err_next = (first_edge ? 1'b0 : err_reg) | !store_ok | bad_end;
                    if (bad_end)
                    begin
                        state_next = last_edge ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        vreq.raddr = end_a;
                        state_next = S_FIND_A;
                    end
                end
            end
            S_FIND_A:
            begin
                if (root_hit)
                begin
                    ra_next    = vrsp.addr;
                    vreq.raddr = b_reg;
                    state_next = S_FIND_B;
                end
                else
                begin
                    vreq.raddr = vrsp.par;
                end
            end
            S_FIND_B:
            begin
                if (root_hit)
                begin
                    rb_next = vrsp.addr;
                    if (ra_reg == vrsp.addr)
                    begin
                        err_next = 1'b1;
                    end
                    vreq.raddr = a_reg;
                    state_next = S_BUMP_A;
                end
                else
                begin
                    vreq.raddr = vrsp.par;
                end
            end
            S_BUMP_A:
            begin
                vreq.we    = 1'b1;
                vreq.waddr = a_reg;
                vreq.wdeg  = (vrsp.deg == DEG_MAX) ? vrsp.deg : vrsp.deg + DEG_W'(1);
                vreq.wpar  = vrsp.par;
                vreq.raddr = b_reg;
                state_next = S_BUMP_B;
            end
            S_BUMP_B:
            begin
                vreq.we    = 1'b1;
                vreq.waddr = b_reg;
                vreq.wdeg  = (vrsp.deg == DEG_MAX) ? vrsp.deg : vrsp.deg + DEG_W'(1);
                vreq.wpar  = vrsp.par;
                // the root may be b itself: read it only after this write lands
                if (ra_reg != rb_reg)
                begin
                    state_next = S_LINK_RD;
                end
                else
                begin
                    state_next = fin_reg ? S_FIN : S_IDLE;
                end
            end
            S_LINK_RD:
            begin
                vreq.raddr = ra_reg;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                vreq.we    = 1'b1;
                vreq.waddr = ra_reg;
                vreq.wdeg  = vrsp.deg;
                vreq.wpar  = rb_reg;
                state_next = fin_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                ecnt_next   = '0;
                err_next    = 1'b0;
                vertex_next = '0;
                last_next   = 1'b1;
                if (n < CFG_W'(2))
                begin
                    done_next   = 1'b1;
                    status_next = ST_SMALL;
                    state_next  = S_IDLE;
                end
                else if (n > MAX_V || err_reg
                         || (8'(ecnt_reg) != 8'(n) - 8'd1)
                         || ({1'b0, maxe_reg} >= n))
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOTREE;
                    state_next  = S_IDLE;
                end
                else if (n == CFG_W'(2))
                begin
                    done_next   = 1'b1;
                    status_next = ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else
                begin
                    u_next     = '0;
                    ocnt_next  = '0;
                    vreq.raddr = '0;
                    state_next = S_WALK_U;
                end
            end
            S_WALK_U:
            begin
                if (vrsp.deg == DEG_W'(1))
                begin
                    leaf_next  = u_reg;
                    vreq.we    = 1'b1;
                    vreq.waddr = u_reg;
                    vreq.wdeg  = '0;
                    vreq.wpar  = vrsp.par;
                    e_next     = '0;
                    e_raddr    = '0;
                    state_next = S_SCAN_V;
                end
                else if (u_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    u_next     = u_reg + VTX_W'(1);
                    vreq.raddr = u_reg + VTX_W'(1);
                end
            end
            S_SCAN_V:
            begin
                if (hit_x || hit_y)
                begin
                    vreq.raddr = other;
                    state_next = S_SCAN_D;
                end
                else if (last_e)
                begin
                    vreq.raddr = '0;
                    state_next = S_DEC;
                end
                else
                begin
                    e_next  = e_reg + EW'(1);
                    e_raddr = e_reg + EW'(1);
                end
            end
            S_SCAN_D:
            begin
                if (vrsp.deg != '0)
                begin
                    do_step = 1'b1;
                end
                else if (last_e)
                begin
                    vreq.raddr = '0;
                    state_next = S_DEC;
                end
                else
                begin
                    e_next     = e_reg + EW'(1);
                    e_raddr    = e_reg + EW'(1);
                    state_next = S_SCAN_V;
                end
            end
            S_DEC:
            begin
                do_step = 1'b1;
            end
            S_NEXT_U:
            begin
                vreq.raddr = u_reg;
                state_next = S_WALK_U;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // remove the leaf's neighbor edge; cascade when it becomes a lower leaf
        if (do_step)
        begin
            if (vrsp.deg != '0)
            begin
                vreq.we    = 1'b1;
                vreq.waddr = vrsp.addr;
                vreq.wdeg  = step_cont ? '0 : dec_deg;
                vreq.wpar  = vrsp.par;
            end
            if (dec_deg != '0)
            begin
                done_next   = 1'b1;
                status_next = ST_ENTRY;
                vertex_next = vrsp.addr;
                last_next   = step_last;
                ocnt_next   = ocnt_reg + VTX_W'(1);
            end
            if (dec_deg != '0 && step_last)
            begin
                state_next = S_IDLE;
            end
            else if (step_cont)
            begin
                leaf_next  = vrsp.addr;
                e_next     = '0;
                e_raddr    = '0;
                state_next = S_SCAN_V;
            end
            else if (u_end)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                u_next     = u_reg + VTX_W'(1);
                state_next = S_NEXT_U;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
            ecnt_reg  <= '0;
            err_reg   <= 1'b0;
            maxe_reg  <= '0;
            vc_reg    <= VC_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            ecnt_reg  <= ecnt_next;
            err_reg   <= err_next;
            maxe_reg  <= maxe_next;
            vc_reg    <= vc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        u_reg      <= u_next;
        leaf_reg   <= leaf_next;
        e_reg      <= e_next;
        ocnt_reg   <= ocnt_next;
        status_reg <= status_next;
        vertex_reg <= vertex_next;
        last_reg   <= last_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign vertex = vertex_reg;
    assign last   = last_reg;

`ifndef ASSERT_OFF
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != ST_ENTRY |-> last_reg && vertex_reg == '0)
        else $error("error or empty result not a single final transfer");

    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && last_reg |-> !busy)
        else $error("sequencer still busy after final transfer");

    a_more_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !last_reg |-> busy)
        else $error("walk stopped before final transfer");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !vreq.we)
        else $error("vertex table written while idle");
`endif

endmodule
